// ===== hw/rtl/gmig_pkg.sv =====
// Shared types and constants for the grid mesh index generator.
`timescale 1ns / 1ps
`default_nettype none

package gmig_pkg;

    localparam int DIM_W     = 11;
    localparam int RECIP_W   = 17;
    localparam int IDX_W     = 20;
    localparam int Q_W       = 26;
    localparam int TRI_N     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 184;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = 3;

    localparam logic [DIM_W-1:0]   DIM_RESET   = DIM_W'(2);
    localparam logic [RECIP_W-1:0] RECIP_RESET = RECIP_W'(65536);
    localparam logic [Q_W-1:0]     Q_MAX       = '1;

    localparam logic KIND_VERTEX   = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VERTS_ACROSS = 2'd0,
        CFG_VERTS_DOWN   = 2'd1,
        CFG_RECIP_ACROSS = 2'd2,
        CFG_RECIP_DOWN   = 2'd3
    } cfg_reg_t;

    // Triangles of the fan, named by their second and third corners.
    typedef enum logic [2:0] {
        TRI_UL_CL = 3'd0,
        TRI_UC_UL = 3'd1,
        TRI_UR_UC = 3'd2,
        TRI_CR_UR = 3'd3,
        TRI_LR_CR = 3'd4,
        TRI_LC_LR = 3'd5,
        TRI_LL_LC = 3'd6,
        TRI_CL_LL = 3'd7
    } tri_t;

    typedef struct packed {
        logic [IDX_W-1:0] center;
        logic [TRI_N-1:0] tri_mask;
    } fan_t;

endpackage

`default_nettype wire

// ===== hw/rtl/grid_mesh_index_generator_top.sv =====
// Top level of the grid mesh index generator: configuration registers and ends.
//
// Each transaction on the s_ channel is one tick over a row-major vertex grid.
// s_tdata bit 0 is restart: when set, the walk goes back to vertex 0 first.
// A tick yields one vertex record (m_tuser 0) and, when the vertex sits on an
// odd row and odd column, two, four or eight triangle records (m_tuser 1)
// fanned around it. m_tlast marks the last record of a tick.
// The first record of a tick passes through the queue and the output register.
// A tick yields 1, 3, 5 or 9 records, one per cycle from the output register
// while the receiver is ready; a four-entry queue lets ticks be accepted
// meanwhile. When the receiver stalls, records wait in the output register,
// the queue fills and s_tready drops. Configuration writes on the cfg_ channel
// are always taken; the user makes them while the block is idle (not enforced).
// After reset the walk is at vertex 0, the grid is 2 by 2 and both
// reciprocals are 1.0 in Q1.16.
`timescale 1ns / 1ps
`default_nettype none

module grid_mesh_index_generator_top #(
    parameter int MAX_SIDE = 1024
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [gmig_pkg::S_TDATA_W-1:0] s_tdata,   // [0] restart
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [19:0] vertex_index, [45:20] pos_x, [71:46] pos_z, [97:72] tex_u,
    // [123:98] tex_v, [143:124] corner_a, [163:144] corner_b, [183:164] corner_c
    output logic [gmig_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [0:0]                          m_tuser,   // [0] kind
    output logic                                m_tlast,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [gmig_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [gmig_pkg::RECIP_W-1:0]   cfg_data
);
    import gmig_pkg::*;

    localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
    localparam int CNT_W   = $clog2(MAX_SIDE);
    localparam int ENTRY_W = SIDE_W + 2 * CNT_W + $bits(fan_t);

    logic [DIM_W-1:0]   verts_across_reg, verts_down_reg;
    logic [RECIP_W-1:0] recip_across_reg, recip_down_reg;
    logic               q_push, q_full, q_pop, q_valid;
    logic [ENTRY_W-1:0] q_in, q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            verts_across_reg <= DIM_RESET;
            verts_down_reg   <= DIM_RESET;
            recip_across_reg <= RECIP_RESET;
            recip_down_reg   <= RECIP_RESET;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                CFG_VERTS_ACROSS: verts_across_reg <= cfg_data[DIM_W-1:0];
                CFG_VERTS_DOWN:   verts_down_reg   <= cfg_data[DIM_W-1:0];
                CFG_RECIP_ACROSS: recip_across_reg <= cfg_data;
                CFG_RECIP_DOWN:   recip_down_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    gmig_front #(
        .MAX_SIDE(MAX_SIDE),
        .SIDE_W  (SIDE_W),
        .CNT_W   (CNT_W),
        .ENTRY_W (ENTRY_W)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .restart     (s_tdata[0]),
        .verts_across(verts_across_reg),
        .verts_down  (verts_down_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    gmig_queue #(
        .DATA_W(ENTRY_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head_valid(q_valid),
        .head_data (q_head)
    );

    gmig_back #(
        .SIDE_W (SIDE_W),
        .CNT_W  (CNT_W),
        .ENTRY_W(ENTRY_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_valid  (q_valid),
        .head_data   (q_head),
        .pop         (q_pop),
        .recip_across(recip_across_reg),
        .recip_down  (recip_down_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser[0]),
        .m_tlast     (m_tlast)
    );

    // A record that does not close its tick is followed at once by a triangle.
    a_fan_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser[0] == KIND_TRIANGLE)
        else $error("fan records interrupted");

    a_vertex_no_corners: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] == KIND_VERTEX |-> m_tdata[183:124] == '0)
        else $error("vertex record carries corners");

    a_tri_center: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] == KIND_TRIANGLE |->
            m_tdata[143:124] == m_tdata[19:0] && m_tdata[123:20] == '0)
        else $error("triangle record malformed");

endmodule

`default_nettype wire

// ===== hw/rtl/gmig_front.sv =====
// Front end: accepts ticks, walks the grid counters and classifies each vertex.
`timescale 1ns / 1ps
`default_nettype none

module gmig_front #(
    parameter int MAX_SIDE = 1024,
    parameter int SIDE_W   = 11,
    parameter int CNT_W    = 10,
    parameter int ENTRY_W  = 59
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic                       restart,
    input  wire logic [gmig_pkg::DIM_W-1:0] verts_across,
    input  wire logic [gmig_pkg::DIM_W-1:0] verts_down,
    input  wire logic                       q_full,
    output logic                            q_push,
    output logic [ENTRY_W-1:0]              q_data
);
    import gmig_pkg::*;

    logic [CNT_W-1:0] row_reg, row_next, col_reg, col_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] row_eff, col_eff;
    logic [IDX_W-1:0] idx_eff;
    logic [SIDE_W-1:0] across, down;
    logic last_col, last_row, center;
    fan_t fan;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [DIM_W-1:0] v);
        if (v < DIM_W'(2)) return SIDE_W'(2);
        if (32'(v) > 32'(MAX_SIDE)) return SIDE_W'(MAX_SIDE);
        return SIDE_W'(v);
    endfunction

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        across  = clamp_side(verts_across);
        down    = clamp_side(verts_down);
        row_eff = restart ? '0 : row_reg;
        col_eff = restart ? '0 : col_reg;
        idx_eff = restart ? '0 : idx_reg;

        last_col = (32'(col_eff) + 32'd1 == 32'(across));
        last_row = (32'(row_eff) + 32'd1 == 32'(down));
        center   = row_eff[0] & col_eff[0];

        fan.center   = idx_eff;
        fan.tri_mask = '0;
        if (center) begin
            fan.tri_mask[TRI_UL_CL] = 1'b1;
            fan.tri_mask[TRI_UC_UL] = 1'b1;
            fan.tri_mask[TRI_UR_UC] = !last_col;
            fan.tri_mask[TRI_CR_UR] = !last_col;
            fan.tri_mask[TRI_LR_CR] = !last_col && !last_row;
            fan.tri_mask[TRI_LC_LR] = !last_col && !last_row;
            fan.tri_mask[TRI_LL_LC] = !last_row;
            fan.tri_mask[TRI_CL_LL] = !last_row;
        end
        q_data = {across, row_eff, col_eff, fan};

        if (32'(col_eff) + 32'd1 >= 32'(across)) begin
            col_next = '0;
            if (32'(row_eff) + 32'd1 >= 32'(down)) begin
                row_next = '0;
                idx_next = '0;
            end else begin
                row_next = row_eff + CNT_W'(1);
                idx_next = idx_eff + IDX_W'(1);
            end
        end else begin
            row_next = row_eff;
            col_next = col_eff + CNT_W'(1);
            idx_next = idx_eff + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
            idx_reg <= '0;
        end else if (q_push) begin
            row_reg <= row_next;
            col_reg <= col_next;
            idx_reg <= idx_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gmig_queue.sv =====
// Short queue of classified vertices between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module gmig_queue #(
    parameter int DATA_W = 59
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic                   head_valid,
    output logic [DATA_W-1:0]      head_data
);
    import gmig_pkg::*;

    logic [DATA_W-1:0] mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + QCNT_W'(1);
        if (pop && !push) count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gmig_back.sv =====
// Back end: emits the vertex and fan triangle records, one per ready cycle.
`timescale 1ns / 1ps
`default_nettype none

module gmig_back #(
    parameter int SIDE_W  = 11,
    parameter int CNT_W   = 10,
    parameter int ENTRY_W = 59
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         head_valid,
    input  wire logic [ENTRY_W-1:0]           head_data,
    output logic                              pop,
    input  wire logic [gmig_pkg::RECIP_W-1:0] recip_across,
    input  wire logic [gmig_pkg::RECIP_W-1:0] recip_down,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [gmig_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast
);
    import gmig_pkg::*;

    localparam int PROD_W = CNT_W + RECIP_W;

    logic                  valid_reg, valid_next;
    logic                  active_reg, active_next;
    logic [TRI_N-1:0]      mask_reg, mask_next;
    logic [IDX_W-1:0]      c_reg, c_next;
    logic [SIDE_W-1:0]     across_reg, across_next;
    logic [M_TDATA_W-1:0]  data_reg, data_next;
    logic                  kind_reg, kind_next;
    logic                  last_reg, last_next;

    logic [SIDE_W-1:0] h_across;
    logic [CNT_W-1:0]  h_row, h_col;
    fan_t              h_fan;
    logic              out_load;
    logic [TRI_N-1:0]  mask_rest;
    tri_t              sel;
    logic [IDX_W-1:0]  a_ext, uc, ul, ur, cl, cr, lc, ll, lr, cb, cc;

    function automatic logic [Q_W-1:0] qmul(input logic [CNT_W-1:0] cnt,
                                             input logic [RECIP_W-1:0] r);
        logic [PROD_W-1:0] p;
        p = PROD_W'(cnt) * PROD_W'(r);
        if (64'(p) > 64'(Q_MAX)) return Q_MAX;
        return Q_W'(p);
    endfunction

    assign {h_across, h_row, h_col, h_fan} = head_data;
    assign out_load = !valid_reg || m_tready;

    always_comb begin
        a_ext = IDX_W'(across_reg);
        uc = c_reg - a_ext;
        ul = uc - IDX_W'(1);
        ur = uc + IDX_W'(1);
        lc = c_reg + a_ext;
        ll = lc - IDX_W'(1);
        lr = lc + IDX_W'(1);
        cl = c_reg - IDX_W'(1);
        cr = c_reg + IDX_W'(1);

        sel = TRI_UL_CL;
        for (int i = TRI_N - 1; i >= 0; i--) begin
            if (mask_reg[i]) sel = tri_t'(i);
        end
        mask_rest = mask_reg & (mask_reg - TRI_N'(1));

        case (sel)
            TRI_UL_CL: begin cb = ul; cc = cl; end
            TRI_UC_UL: begin cb = uc; cc = ul; end
            TRI_UR_UC: begin cb = ur; cc = uc; end
            TRI_CR_UR: begin cb = cr; cc = ur; end
            TRI_LR_CR: begin cb = lr; cc = cr; end
            TRI_LC_LR: begin cb = lc; cc = lr; end
            TRI_LL_LC: begin cb = ll; cc = lc; end
            TRI_CL_LL: begin cb = cl; cc = ll; end
            default:   begin cb = ul; cc = cl; end
        endcase
    end

    always_comb begin
        pop         = 1'b0;
        valid_next  = valid_reg;
        active_next = active_reg;
        mask_next   = mask_reg;
        c_next      = c_reg;
        across_next = across_reg;
        data_next   = data_reg;
        kind_next   = kind_reg;
        last_next   = last_reg;
        if (out_load) begin
            if (active_reg) begin
                valid_next  = 1'b1;
                kind_next   = KIND_TRIANGLE;
                data_next   = {cc, cb, c_reg, {4 * Q_W{1'b0}}, c_reg};
                mask_next   = mask_rest;
                last_next   = (mask_rest == '0);
                active_next = (mask_rest != '0);
            end else if (head_valid) begin
                pop         = 1'b1;
                valid_next  = 1'b1;
                kind_next   = KIND_VERTEX;
                data_next   = {{3 * IDX_W{1'b0}},
                               qmul(h_col, recip_across),
                               qmul(h_row, recip_down),
                               qmul(h_row, recip_across),
                               qmul(h_col, recip_down),
                               h_fan.center};
                c_next      = h_fan.center;
                across_next = h_across;
                mask_next   = h_fan.tri_mask;
                last_next   = (h_fan.tri_mask == '0);
                active_next = (h_fan.tri_mask != '0);
            end else begin
                valid_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            active_reg <= 1'b0;
        end else begin
            valid_reg  <= valid_next;
            active_reg <= active_next;
        end
        mask_reg   <= mask_next;
        c_reg      <= c_next;
        across_reg <= across_next;
        data_reg   <= data_next;
        kind_reg   <= kind_next;
        last_reg   <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire
